// ===== hw/rtl/aes_pkg.sv =====
// Package for the AES-128 ECB/CBC cipher: widths, register indexes, payload types,
// S-box functions and the round helpers shared by the round unit and key expander.
// No dependencies.
`default_nettype none
package aes_pkg;

  localparam int unsigned RoundCount = 10;
  localparam int unsigned KeyWords   = 4 * (RoundCount + 1);
  localparam int unsigned HalfW      = 64;
  localparam int unsigned CfgIdxW    = 3;
  localparam logic [8:0]  FieldPoly  = 9'h11b;
  localparam logic [7:0]  HighBit    = 8'h80;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH   = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_IV_HIGH    = 3'd2,
    REG_IV_LOW     = 3'd3,
    REG_CHAIN_MODE = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYX,
    ST_RUN,
    ST_DONE
  } aes_state_e;

  typedef struct packed {
    logic             command;
    logic             first_block;
    logic [HalfW-1:0] block_high;
    logic [HalfW-1:0] block_low;
  } blk_in_t;

  typedef struct packed {
    logic [HalfW-1:0] result_high;
    logic [HalfW-1:0] result_low;
  } blk_out_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    logic [8:0] s;
    s = {a, 1'b0};
    if ((a & HighBit) != 8'h00) s = s ^ FieldPoly;
    return s[7:0];
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inv(input logic [7:0] a);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = a;
    // Exponent 254 = 8'b1111_1110.
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, b);
      b = gf_mul(b, b);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int unsigned n);
    logic [15:0] d;
    d = {b, b} << n;
    return d[15:8];
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] b);
    logic [7:0] x;
    x = gf_inv(b);
    return x ^ rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 3) ^ rotl8(x, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_calc(input logic [7:0] s);
    return gf_inv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  // The S-box tables are built at elaboration; lookups are 256-entry constants.
  typedef logic [7:0] sbox_t [256];

  function automatic sbox_t build_sbox(input logic inverse);
    sbox_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inverse ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    return t;
  endfunction

  localparam sbox_t SboxFwd = build_sbox(1'b0);
  localparam sbox_t SboxInv = build_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SboxFwd[w[31:24]], SboxFwd[w[23:16]], SboxFwd[w[15:8]], SboxFwd[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes_stream_if.sv =====
// Valid/ready stream interface carrying one transaction's payload.
// Depends on no package; the payload type is a parameter.
`default_nettype none
interface aes_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/aes_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/aes_round.sv =====
// One shared AES round, forward or inverse, applied to a 128-bit state.
// Depends on aes_pkg for the S-box tables and GF helpers.
`default_nettype none
module aes_round (
  input  wire logic         inverse_i,
  input  wire logic         last_i,
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] round_key_i,
  output logic      [127:0] state_o
);
  import aes_pkg::*;

  // Byte k of the state is state[127-8k -: 8], column k/4, row k%4.
  logic [7:0] s   [16];
  logic [7:0] t   [16];
  logic [7:0] u   [16];
  logic [7:0] m   [16];

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      s[k] = state_i[127-8*k -: 8];
    end
    // Forward: SubBytes, ShiftRows. Inverse: InvShiftRows, InvSubBytes.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse_i) t[4*c+r] = SboxInv[s[4*((c-r+4)%4)+r]];
        else           t[4*c+r] = SboxFwd[s[4*((c+r)%4)+r]];
      end
    end
    // Forward adds the key after mixing; inverse adds it before.
    for (int k = 0; k < 16; k++) begin
      u[k] = inverse_i ? (t[k] ^ round_key_i[127-8*k -: 8]) : t[k];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse_i) begin
          m[4*c+r] = gf_mul(8'd14, u[4*c+r]) ^ gf_mul(8'd11, u[4*c+(r+1)%4])
                   ^ gf_mul(8'd13, u[4*c+(r+2)%4]) ^ gf_mul(8'd9, u[4*c+(r+3)%4]);
        end else begin
          m[4*c+r] = xt(u[4*c+r]) ^ xt(u[4*c+(r+1)%4]) ^ u[4*c+(r+1)%4]
                   ^ u[4*c+(r+2)%4] ^ u[4*c+(r+3)%4];
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      if (inverse_i) state_o[127-8*k -: 8] = last_i ? u[k] : m[k];
      else state_o[127-8*k -: 8] = (last_i ? u[k] : m[k]) ^ round_key_i[127-8*k -: 8];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/aes128_ecb_cbc_cipher.sv =====
// Top level of the AES-128 ECB/CBC cipher: sequencer, key expansion into
// the round key RAM, chaining and output register. Depends on aes_pkg,
// aes_stream_if, aes_ram and aes_round.
//
//  channel  | direction | payload                                  | handshake
//  in_if    | sink      | command, first_block, block_high/low     | valid/ready
//  out_if   | source    | result_high, result_low                  | valid/ready
//  cfg      | input     | cfg_we_i, cfg_idx_i, cfg_data_i          | write enable
//
// The result appears once all 44 round key words have been read, one per cycle,
// through the single read port of the round key RAM; the first round key is added
// directly, and each later one takes one pass through the shared round unit.
// The result is held in a register until taken; the next transaction can be
// accepted at the edge after that, so blocks are processed one at a time.
// After reset, and after each key write once idle, a setup step and a key expansion
// of the 44 round key words run, during which no transaction is accepted.
`default_nettype none
module aes128_ecb_cbc_cipher #(
  parameter int unsigned RoundCountP = aes_pkg::RoundCount
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [aes_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [aes_pkg::HalfW-1:0]    cfg_data_i,
  aes_stream_if.sink                        in_if,
  aes_stream_if.source                      out_if
);
  import aes_pkg::*;

  localparam int unsigned NumWords = 4 * (RoundCountP + 1);
  localparam int unsigned AddrW    = $clog2(NumWords);
  localparam int unsigned CntW     = $clog2(NumWords + 1);
  localparam int unsigned StepW    = CntW - 2;

  aes_state_e state_q, state_d;

  logic [63:0]  key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic         mode_q;
  logic [127:0] chain_q, chain_d;
  logic [127:0] blk_q, blk_d;
  logic [127:0] res_q, res_d;
  logic         dec_q, dec_d;
  logic         kx_pend_q, kx_pend_d;

  // Key expansion: window of the last four words.
  logic [31:0]      kw_q [4];
  logic [31:0]      kw_d [4];
  logic [AddrW-1:0] kx_idx_q, kx_idx_d;
  logic [7:0]       rcon_q, rcon_d;

  logic [CntW-1:0]  cnt_q, cnt_d;     // round key words read so far
  logic [95:0]      rkey_q, rkey_d;   // words already returned by the RAM
  logic [127:0]     rkey_full;
  logic [StepW-1:0] fetch_step, apply_step, key_rnd;
  logic             key_done;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;
  logic [31:0]      kx_new;
  logic [127:0]     round_out;
  logic             accept;

  assign accept = in_if.valid && in_if.ready;

  // A round key is complete when its fourth word comes out of the RAM.
  assign fetch_step = cnt_q[CntW-1:2];
  assign apply_step = fetch_step - StepW'(1);
  assign key_rnd    = dec_q ? StepW'(RoundCountP) - fetch_step : fetch_step;
  assign rkey_full  = {rkey_q, ram_rdata};
  assign key_done   = (state_q == ST_RUN) && (cnt_q != '0) && (cnt_q[1:0] == 2'b00);

  aes_ram #(.Width(32), .Depth(NumWords)) u_keys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  aes_round u_round (
    .inverse_i   (dec_q),
    .last_i      (apply_step == StepW'(RoundCountP)),
    .state_i     (blk_q),
    .round_key_i (rkey_full),
    .state_o     (round_out)
  );

  always_comb begin
    logic [31:0] t;
    t = kw_q[3];
    if (kx_idx_q[1:0] == 2'b00) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h0};
    end
    kx_new = kw_q[0] ^ t;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (kx_pend_q) state_d = ST_KEYX;
        else if (accept) state_d = ST_RUN;
      end
      ST_KEYX: if (kx_idx_q == AddrW'(NumWords - 1)) state_d = ST_IDLE;
      ST_RUN: if (cnt_q == CntW'(NumWords)) state_d = ST_DONE;
      ST_DONE: if (out_if.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [127:0] cin, din, r;
    kw_d      = kw_q;
    kx_idx_d  = kx_idx_q;
    rcon_d    = rcon_q;
    kx_pend_d = kx_pend_q;
    ram_we    = 1'b0;
    ram_waddr = kx_idx_q;
    ram_wdata = kx_new;
    ram_raddr = '0;
    cnt_d     = cnt_q;
    rkey_d    = rkey_q;
    blk_d     = blk_q;
    res_d     = res_q;
    dec_d     = dec_q;
    chain_d   = chain_q;
    cin       = in_if.data.first_block ? {iv_hi_q, iv_lo_q} : chain_q;
    din       = {in_if.data.block_high, in_if.data.block_low};
    r         = round_out;

    unique case (state_q)
      ST_IDLE: begin
        if (kx_pend_q) begin
          // Load the first four words, written over the next cycles.
          kw_d[0]   = key_hi_q[63:32];
          kw_d[1]   = key_hi_q[31:0];
          kw_d[2]   = key_lo_q[63:32];
          kw_d[3]   = key_lo_q[31:0];
          kx_idx_d  = '0;
          rcon_d    = 8'h01;
          kx_pend_d = 1'b0;
        end else if (accept) begin
          chain_d = cin;
          dec_d = in_if.data.command;
          blk_d = (!in_if.data.command && mode_q) ? (din ^ cin) : din;
          res_d = din;  // ciphertext kept for the decrypt chain update
          cnt_d = '0;
        end
      end
      ST_KEYX: begin
        // Words 0..3 go in first, then one expanded word per cycle.
        ram_we = 1'b1;
        if (kx_idx_q < AddrW'(4)) begin
          ram_wdata = kw_q[kx_idx_q[1:0]];
          kx_idx_d = kx_idx_q + AddrW'(1);
        end else begin
          kw_d[0] = kw_q[1];
          kw_d[1] = kw_q[2];
          kw_d[2] = kw_q[3];
          kw_d[3] = kx_new;
          if (kx_idx_q[1:0] == 2'b00) rcon_d = xt(rcon_q);
          if (kx_idx_q != AddrW'(NumWords - 1)) kx_idx_d = kx_idx_q + AddrW'(1);
        end
      end
      ST_RUN: begin
        // One word read per cycle; decryption walks the round keys backwards.
        if (cnt_q != CntW'(NumWords)) begin
          ram_raddr = AddrW'({key_rnd, cnt_q[1:0]});
          cnt_d = cnt_q + CntW'(1);
        end
        rkey_d = {rkey_q[63:0], ram_rdata};
        if (key_done) begin
          if (apply_step == '0) blk_d = blk_q ^ rkey_full;
          else blk_d = round_out;
        end
        if (cnt_q == CntW'(NumWords)) begin
          if (mode_q) begin
            if (dec_q) begin
              r       = round_out ^ chain_q;
              chain_d = res_q;
            end else begin
              chain_d = round_out;
            end
          end
          res_d = r;
        end
      end
      ST_DONE: ;
      default: ;
    endcase

    // Key register writes start a fresh expansion.
    if (cfg_we_i && (cfg_idx_i == REG_KEY_HIGH || cfg_idx_i == REG_KEY_LOW))
      kx_pend_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kx_pend_q   <= 1'b1;
      key_hi_q    <= '0;
      key_lo_q    <= '0;
      iv_hi_q     <= '0;
      iv_lo_q     <= '0;
      mode_q      <= 1'b0;
      chain_q     <= '0;
      kx_idx_q    <= '0;
      rcon_q      <= 8'h01;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      kx_pend_q   <= kx_pend_d;
      chain_q     <= chain_d;
      kx_idx_q    <= kx_idx_d;
      rcon_q      <= rcon_d;
      cnt_q       <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_KEY_HIGH:   key_hi_q <= cfg_data_i;
          REG_KEY_LOW:    key_lo_q <= cfg_data_i;
          REG_IV_HIGH:    iv_hi_q  <= cfg_data_i;
          REG_IV_LOW:     iv_lo_q  <= cfg_data_i;
          REG_CHAIN_MODE: mode_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kw_q   <= kw_d;
    rkey_q <= rkey_d;
    blk_q  <= blk_d;
    res_q  <= res_d;
    dec_q  <= dec_d;
  end

  assign in_if.ready  = (state_q == ST_IDLE) && !kx_pend_q;
  assign out_if.valid = (state_q == ST_DONE);
  assign out_if.data  = res_q;
endmodule
`default_nettype wire

// ===== hw/rtl/aes_checker.sv =====
// Port-level checker for the AES-128 cipher, bound to the top level.
// Depends on aes_pkg for the register indexes.
`default_nettype none
module aes_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        cfg_we_i,
  input wire logic [aes_pkg::CfgIdxW-1:0] cfg_idx_i
);
  import aes_pkg::*;

  logic key_write;
  assign key_write = cfg_we_i && (cfg_idx_i == REG_KEY_HIGH || cfg_idx_i == REG_KEY_LOW);

  // One block in flight: no acceptance while a result waits.
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken while result pending");

  // A block takes several cycles, so no result follows an accept at once.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i) else $error("result too early");

  // A result leaves only through its handshake.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("result dropped");

  // A key write blocks input on the following cycle while keys expand.
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_write |=> !in_ready_i) else $error("input ready during key expansion");
endmodule

bind aes128_ecb_cbc_cipher aes_checker u_aes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i)
);
`default_nettype wire
